[rtl/core/thpc_pkg.sv]
// ----------------------------------------------------------------------------
// thpc_pkg: shared types and constants of the TLS hello packet classifier
// Header offsets, protocol codes, read step codes and controller types.
// ----------------------------------------------------------------------------
package thpc_pkg;

    localparam int HEADER_BYTES_DEF = 128;

    localparam logic [15:0] GUARDED_PORT_RST = 16'd443;

    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_TCP       = 8'h06;
    localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] VER_TLS10       = 16'h0301;
    localparam logic [15:0] VER_TLS11       = 16'h0302;

    // Header offsets fit in seven bits: no access reaches past byte 99
    localparam int OFS_W = 7;

    localparam logic [OFS_W-1:0] OFS_ETYPE_HI = 7'd12;
    localparam logic [OFS_W-1:0] OFS_ETYPE_LO = 7'd13;
    localparam logic [OFS_W-1:0] OFS_VER_IHL  = 7'd14;
    localparam logic [OFS_W-1:0] OFS_PROTO    = 7'd23;
    localparam logic [OFS_W-1:0] OFS_SRC_IP   = 7'd26;
    localparam logic [OFS_W-1:0] LEN_ETH      = 7'd14;
    localparam logic [OFS_W-1:0] LEN_ETH_IP   = 7'd34;
    localparam logic [OFS_W-1:0] LEN_TCP      = 7'd20;
    localparam logic [OFS_W-1:0] LEN_TLS      = 7'd6;
    localparam logic [OFS_W-1:0] OFS_HS_TYPE  = 7'd5;

    // Header read sequence, one byte per step
    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] STEP_ETYPE_HI = 5'd0;
    localparam logic [STEP_W-1:0] STEP_ETYPE_LO = 5'd1;
    localparam logic [STEP_W-1:0] STEP_VER_IHL  = 5'd2;
    localparam logic [STEP_W-1:0] STEP_PROTO    = 5'd3;
    localparam logic [STEP_W-1:0] STEP_IP_FIRST = 5'd4;
    localparam logic [STEP_W-1:0] STEP_IP_LAST  = 5'd11;
    localparam logic [STEP_W-1:0] STEP_SPORT_HI = 5'd12;
    localparam logic [STEP_W-1:0] STEP_SPORT_LO = 5'd13;
    localparam logic [STEP_W-1:0] STEP_DPORT_HI = 5'd14;
    localparam logic [STEP_W-1:0] STEP_DPORT_LO = 5'd15;
    localparam logic [STEP_W-1:0] STEP_REC_KIND = 5'd16;
    localparam logic [STEP_W-1:0] STEP_VER_HI   = 5'd17;
    localparam logic [STEP_W-1:0] STEP_VER_LO   = 5'd18;
    localparam logic [STEP_W-1:0] STEP_HS_TYPE  = 5'd19;
    localparam logic [STEP_W-1:0] STEP_LAST     = STEP_HS_TYPE;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_INFO   = 2'd1,
        EV_LEGACY = 2'd2
    } t_event_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_EVAL
    } t_state;

    typedef struct packed {
        logic              wr;
        logic              last;
        logic              rd_en;
        logic [STEP_W-1:0] rd_step;
        logic              eval;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    // Header offset read at a given step; tcp is the TCP header offset
    function automatic logic [OFS_W-1:0] step_offset(input logic [STEP_W-1:0] step,
                                                      input logic [OFS_W-1:0]  tcp);
        logic [OFS_W-1:0] ofs;
        ofs = OFS_ETYPE_HI;
        priority if (step == STEP_ETYPE_HI) begin
            ofs = OFS_ETYPE_HI;
        end else if (step == STEP_ETYPE_LO) begin
            ofs = OFS_ETYPE_LO;
        end else if (step == STEP_VER_IHL) begin
            ofs = OFS_VER_IHL;
        end else if (step == STEP_PROTO) begin
            ofs = OFS_PROTO;
        end else if (step <= STEP_IP_LAST) begin
            ofs = OFS_SRC_IP + OFS_W'(step - STEP_IP_FIRST);
        end else if (step <= STEP_DPORT_LO) begin
            ofs = tcp + OFS_W'(step - STEP_SPORT_HI);
        end else if (step <= STEP_VER_LO) begin
            ofs = tcp + LEN_TCP + OFS_W'(step - STEP_REC_KIND);
        end else begin
            ofs = tcp + LEN_TCP + OFS_HS_TYPE;
        end
        return ofs;
    endfunction

endpackage

[rtl/core/thpc_ctrl.sv]
// ----------------------------------------------------------------------------
// thpc_ctrl: classifier controller
// Accepts frame words, then steps the header read sequence and evaluation.
// ----------------------------------------------------------------------------
module thpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  thpc_pkg::t_dp_sts i_sts,
    output thpc_pkg::t_dp_cmd o_cmd
);

    thpc_pkg::t_state                   r_state, n_state;
    logic [thpc_pkg::STEP_W-1:0]        r_step,  n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= thpc_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = '0;
        unique case (r_state)
            thpc_pkg::ST_IDLE: begin
                if (i_in_valid && i_in_last) begin
                    n_state = thpc_pkg::ST_READ;
                end
            end
            thpc_pkg::ST_READ: begin
                if (r_step == thpc_pkg::STEP_LAST) begin
                    n_state = thpc_pkg::ST_DRAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            thpc_pkg::ST_DRAIN: begin
                n_state = thpc_pkg::ST_EVAL;
            end
            thpc_pkg::ST_EVAL: begin
                if (i_sts.out_free) begin
                    n_state = thpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = thpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == thpc_pkg::ST_IDLE);
        o_cmd.wr      = o_in_ready && i_in_valid;
        o_cmd.last    = o_cmd.wr && i_in_last;
        o_cmd.rd_en   = (r_state == thpc_pkg::ST_READ);
        o_cmd.rd_step = r_step;
        o_cmd.eval    = (r_state == thpc_pkg::ST_EVAL);
    end

endmodule

[rtl/core/thpc_datapath.sv]
// ----------------------------------------------------------------------------
// thpc_datapath: header store, field capture and verdict
// Stores leading frame bytes, reads header fields back and builds the result.
// ----------------------------------------------------------------------------
module thpc_datapath #(
    parameter int HEADER_BYTES = thpc_pkg::HEADER_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  thpc_pkg::t_dp_cmd i_cmd,
    output thpc_pkg::t_dp_sts o_sts,
    input  logic [7:0]        i_byte,
    input  logic              i_cfg_valid,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_drop,
    output logic [1:0]        o_event_kind,
    output logic [31:0]       o_src_addr,
    output logic [31:0]       o_dst_addr,
    output logic [15:0]       o_src_port,
    output logic [15:0]       o_dst_port,
    output logic [15:0]       o_rec_version,
    output logic [7:0]        o_rec_kind
);

    localparam int AW = $clog2(HEADER_BYTES);
    localparam int CW = $clog2(HEADER_BYTES + 1);
    localparam int LW = $clog2(HEADER_BYTES + 2);
    localparam int OW = thpc_pkg::OFS_W;

    logic [7:0]                  r_mem [HEADER_BYTES];
    logic [7:0]                  r_rd_data;
    logic [CW-1:0]               r_count;
    logic [LW-1:0]               r_len;
    logic [15:0]                 r_guard_port;
    logic                        r_cap_vld;
    logic [thpc_pkg::STEP_W-1:0] r_cap_step;

    logic [15:0] r_etype;
    logic [3:0]  r_ihl;
    logic [7:0]  r_proto;
    logic [63:0] r_ip_pair;
    logic [15:0] r_sport;
    logic [15:0] r_dport;
    logic [7:0]  r_kind;
    logic [15:0] r_ver;
    logic [7:0]  r_hs_type;

    logic                 r_out_valid;
    logic                 r_drop;
    thpc_pkg::t_event_kind r_event;
    logic [31:0]          r_src_addr, r_dst_addr;
    logic [15:0]          r_src_port, r_dst_port, r_rec_version;
    logic [7:0]           r_rec_kind;

    logic [OW-1:0] w_tcp;
    logic [OW-1:0] w_ofs;
    logic [LW-1:0] w_len_next;
    logic          w_hit;
    logic          w_legacy;

    assign w_tcp      = thpc_pkg::LEN_ETH + OW'({r_ihl, 2'b00});
    assign w_ofs      = thpc_pkg::step_offset(i_cmd.rd_step, w_tcp);
    assign w_len_next = LW'(r_count) + 1'b1;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && (r_count < CW'(HEADER_BYTES))) begin
            r_mem[r_count[AW-1:0]] <= i_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[AW'(w_ofs)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_guard_port <= thpc_pkg::GUARDED_PORT_RST;
            r_cap_vld    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_guard_port <= i_cfg_data;
            end
            if (i_cmd.last) begin
                r_count <= '0;
            end else if (i_cmd.wr && (r_count < CW'(HEADER_BYTES))) begin
                r_count <= r_count + 1'b1;
            end
            r_cap_vld <= i_cmd.rd_en;
            if (i_cmd.eval && o_sts.out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap_step <= i_cmd.rd_step;
        if (i_cmd.last) begin
            r_len <= w_len_next;
        end
        if (r_cap_vld) begin
            priority if (r_cap_step == thpc_pkg::STEP_ETYPE_HI) begin
                r_etype[15:8] <= r_rd_data;
            end else if (r_cap_step == thpc_pkg::STEP_ETYPE_LO) begin
                r_etype[7:0] <= r_rd_data;
            end else if (r_cap_step == thpc_pkg::STEP_VER_IHL) begin
                r_ihl <= r_rd_data[3:0];
            end else if (r_cap_step == thpc_pkg::STEP_PROTO) begin
                r_proto <= r_rd_data;
            end else if (r_cap_step <= thpc_pkg::STEP_IP_LAST) begin
                r_ip_pair <= {r_ip_pair[55:0], r_rd_data};
            end else if (r_cap_step == thpc_pkg::STEP_SPORT_HI) begin
                r_sport[15:8] <= r_rd_data;
            end else if (r_cap_step == thpc_pkg::STEP_SPORT_LO) begin
                r_sport[7:0] <= r_rd_data;
            end else if (r_cap_step == thpc_pkg::STEP_DPORT_HI) begin
                r_dport[15:8] <= r_rd_data;
            end else if (r_cap_step == thpc_pkg::STEP_DPORT_LO) begin
                r_dport[7:0] <= r_rd_data;
            end else if (r_cap_step == thpc_pkg::STEP_REC_KIND) begin
                r_kind <= r_rd_data;
            end else if (r_cap_step == thpc_pkg::STEP_VER_HI) begin
                r_ver[15:8] <= r_rd_data;
            end else if (r_cap_step == thpc_pkg::STEP_VER_LO) begin
                r_ver[7:0] <= r_rd_data;
            end else begin
                r_hs_type <= r_rd_data;
            end
        end
    end

    always_comb begin
        w_hit = (r_len >= LW'(thpc_pkg::LEN_ETH)) && (r_etype == thpc_pkg::ETHERTYPE_IPV4)
             && (r_len >= LW'(thpc_pkg::LEN_ETH_IP)) && (r_proto == thpc_pkg::PROTO_TCP)
             && (r_len >= LW'(w_tcp + thpc_pkg::LEN_TCP))
             && ((r_dport == r_guard_port) || (r_sport == r_guard_port))
             && (r_len >= LW'(w_tcp + thpc_pkg::LEN_TCP + thpc_pkg::LEN_TLS))
             && (r_kind == thpc_pkg::REC_HANDSHAKE)
             && (r_hs_type == thpc_pkg::HS_CLIENT_HELLO);
        w_legacy = (r_ver == thpc_pkg::VER_TLS10) || (r_ver == thpc_pkg::VER_TLS11);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && o_sts.out_free) begin
            if (w_hit) begin
                r_drop        <= w_legacy;
                r_event       <= w_legacy ? thpc_pkg::EV_LEGACY : thpc_pkg::EV_INFO;
                r_src_addr    <= r_ip_pair[63:32];
                r_dst_addr    <= r_ip_pair[31:0];
                r_src_port    <= r_sport;
                r_dst_port    <= r_dport;
                r_rec_version <= r_ver;
                r_rec_kind    <= r_kind;
            end else begin
                r_drop        <= 1'b0;
                r_event       <= thpc_pkg::EV_NONE;
                r_src_addr    <= '0;
                r_dst_addr    <= '0;
                r_src_port    <= '0;
                r_dst_port    <= '0;
                r_rec_version <= '0;
                r_rec_kind    <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drop        = r_drop;
    assign o_event_kind  = r_event;
    assign o_src_addr    = r_src_addr;
    assign o_dst_addr    = r_dst_addr;
    assign o_src_port    = r_src_port;
    assign o_dst_port    = r_dst_port;
    assign o_rec_version = r_rec_version;
    assign o_rec_kind    = r_rec_kind;

endmodule

[rtl/core/tls_hello_packet_classifier_unit.sv]
// ----------------------------------------------------------------------------
// tls_hello_packet_classifier_unit: TLS ClientHello classifier, top level
// Classifies Ethernet/IPv4/TCP frames and reports one verdict per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one frame byte per word in s_axis_tdata, tlast on the final
//   byte. Bytes are taken one per cycle while the block is collecting a frame.
//   Master stream: one result word per frame, event kind in m_axis_tuser.
//   Config channel: writes the guarded TCP port (reset value 443); write only
//   while no frame is in flight.
// Frame sequence:
//   After the last byte of a frame, the controller reads 20 header bytes, one
//   per step, through the single read port of the header store, passes a
//   drain state for the last read data and then evaluates; evaluation waits
//   while a previous result word is still held. The result word is then registered.
//   s_axis_tready is low from the last byte until the result is registered.
// Reset and stall:
//   Synchronous active-low reset clears control state and restores the port.
//   A stalled result holds in the output register; the next frame may stream
//   in meanwhile, and its evaluation waits until the held word is taken.
// ----------------------------------------------------------------------------
module tls_hello_packet_classifier_unit #(
    parameter int HEADER_BYTES = thpc_pkg::HEADER_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // frame_byte
    input  logic [7:0]   i_s_axis_tdata,
    input  logic         i_s_axis_tlast,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // guarded_port
    input  logic [15:0]  i_cfg_data,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    // drop_frame, source_address, dest_address, source_port, dest_port,
    // record_version, record_kind, zero fill
    output logic [127:0] o_m_axis_tdata,
    // event_kind
    output logic [1:0]   o_m_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready
);

    thpc_pkg::t_dp_cmd w_cmd;
    thpc_pkg::t_dp_sts w_sts;

    logic        w_drop;
    logic [31:0] w_src_addr, w_dst_addr;
    logic [15:0] w_src_port, w_dst_port, w_rec_version;
    logic [7:0]  w_rec_kind;

    assign o_cfg_ready = 1'b1;

    thpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_last  (i_s_axis_tlast),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    thpc_datapath #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_byte        (i_s_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_drop        (w_drop),
        .o_event_kind  (o_m_axis_tuser),
        .o_src_addr    (w_src_addr),
        .o_dst_addr    (w_dst_addr),
        .o_src_port    (w_src_port),
        .o_dst_port    (w_dst_port),
        .o_rec_version (w_rec_version),
        .o_rec_kind    (w_rec_kind)
    );

    assign o_m_axis_tdata = {7'd0, w_rec_kind, w_rec_version, w_dst_port, w_src_port,
                             w_dst_addr, w_src_addr, w_drop};

    a_last_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> !o_s_axis_tready)
        else $error("input taken after frame end");

    a_no_input_while_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_en |-> !o_s_axis_tready)
        else $error("input ready during header read");

    a_result_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_cmd.eval))
        else $error("result raised outside evaluation");

    a_drop_is_legacy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[0]) |-> (o_m_axis_tuser == thpc_pkg::EV_LEGACY))
        else $error("drop without legacy event");

endmodule

[dv/tls_hello_packet_classifier_unit_test.sv]
// ----------------------------------------------------------------------------
// tls_hello_packet_classifier_unit_test: self-checking bench of the classifier
// Streams Ethernet frames byte by byte, takes one verdict word per frame from
// the directed table or predicts it from the leading header bytes and the
// guarded port, and checks every field of each result word. A directed table
// covers the verdict classes, short and long frames and the port extremes;
// random well-formed, broken and noise frames follow, under bursty input and
// a stalling result side.
module tls_hello_packet_classifier_unit_test;

    localparam int HEADER_BYTES  = thpc_pkg::HEADER_BYTES_DEF;
    localparam int DIRECTED_ROWS = 25;
    localparam int ITEM_TARGET   = 1100;
    localparam int RANDOM_FRAMES = 6;
    localparam int PHASE_FRAMES  = 3;
    localparam int SETTLE_CYCLES = 32;

    localparam logic [31:0] HOST_A = 32'hC0A8_0A01;
    localparam logic [31:0] HOST_B = 32'h0A00_0002;

    typedef struct packed {
        logic                  drop;
        thpc_pkg::t_event_kind ev;
        logic [31:0]           saddr;
        logic [31:0]           daddr;
        logic [15:0]           sport;
        logic [15:0]           dport;
        logic [15:0]           ver;
        logic [7:0]            kind;
    } t_verdict;

    typedef struct packed {
        logic [8:0]            len;
        logic [15:0]           port;
        logic [3:0]            ihl;
        logic [15:0]           etype;
        logic [7:0]            proto;
        logic [31:0]           saddr;
        logic [31:0]           daddr;
        logic [15:0]           sport;
        logic [15:0]           dport;
        logic [7:0]            rkind;
        logic [15:0]           ver;
        logic [7:0]            hs;
        logic                  pinned;
        logic                  drop;
        thpc_pkg::t_event_kind ev;
    } t_frame_row;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_COMB,
        RX_LONG
    } t_rx_mode;

    logic         i_clk;
    logic         i_rst_n;
    logic [7:0]   i_s_axis_tdata;
    logic         i_s_axis_tlast;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [15:0]  i_cfg_data;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [127:0] o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;

    // predictor state
    logic [7:0]   frame_head [0:HEADER_BYTES-1];
    int unsigned  head_count = 0;
    logic [15:0]  port_model = thpc_pkg::GUARDED_PORT_RST;

    t_verdict     pending_verdicts [$];
    t_verdict     pinned_verdicts [$];
    bit           pinned_flags [$];

    logic [7:0]   frame_buf [0:511];
    int unsigned  frame_len;
    int unsigned  frames_sent   = 0;
    int unsigned  verdicts_seen = 0;
    int unsigned  bytes_sent    = 0;
    int unsigned  burst_left    = 0;
    bit           gaps_on       = 1'b1;
    int unsigned  fail_count    = 0;

    int unsigned  rx_tick = 0;
    t_rx_mode     rx_mode = RX_OPEN;

    t_verdict     got_word;
    t_verdict     want_word;

    t_frame_row directed_rows [0:DIRECTED_ROWS-1] = '{
        '{9'd60,  16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51000, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0303,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_INFO},
        '{9'd60,  16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51001, 16'd443, thpc_pkg::REC_HANDSHAKE, thpc_pkg::VER_TLS10,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b1, thpc_pkg::EV_LEGACY},
        '{9'd75,  16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_B, HOST_A, 16'd443, 16'd50000, thpc_pkg::REC_HANDSHAKE, thpc_pkg::VER_TLS11,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b1, thpc_pkg::EV_LEGACY},
        '{9'd60,  16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51002, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0300,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_INFO},
        '{9'd60,  16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          32'hFFFF_FFFF, 32'h0, 16'd65535, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0304,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_INFO},
        '{9'd60,  16'd443,   4'd5,  16'h86DD, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51003, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0303,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_NONE},
        '{9'd60,  16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, 8'h11,
          HOST_A, HOST_B, 16'd51004, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0303,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_NONE},
        '{9'd60,  16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd80, 16'd8080, thpc_pkg::REC_HANDSHAKE, 16'h0303,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_NONE},
        '{9'd60,  16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51005, 16'd443, 8'h17, 16'h0303,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_NONE},
        '{9'd60,  16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51006, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0303,
          8'h02, 1'b1, 1'b0, thpc_pkg::EV_NONE},
        '{9'd1,   16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51007, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0303,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_NONE},
        '{9'd13,  16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51008, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0303,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_NONE},
        '{9'd33,  16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51009, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0303,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_NONE},
        '{9'd53,  16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51010, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0303,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_NONE},
        '{9'd59,  16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51011, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0303,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_NONE},
        '{9'd100, 16'd443,   4'd15, thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51012, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0303,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_INFO},
        '{9'd40,  16'd443,   4'd0,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51013, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0303,
          thpc_pkg::HS_CLIENT_HELLO, 1'b0, 1'b0, thpc_pkg::EV_NONE},
        '{9'd48,  16'd443,   4'd2,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51014, 16'd443, thpc_pkg::REC_HANDSHAKE, thpc_pkg::VER_TLS10,
          thpc_pkg::HS_CLIENT_HELLO, 1'b0, 1'b0, thpc_pkg::EV_NONE},
        '{9'd128, 16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51015, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0303,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_INFO},
        '{9'd129, 16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51016, 16'd443, thpc_pkg::REC_HANDSHAKE, thpc_pkg::VER_TLS10,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b1, thpc_pkg::EV_LEGACY},
        '{9'd131, 16'd443,   4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd443, 16'd51017, thpc_pkg::REC_HANDSHAKE, thpc_pkg::VER_TLS11,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b1, thpc_pkg::EV_LEGACY},
        '{9'd60,  16'd0,     4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd0, 16'd0, thpc_pkg::REC_HANDSHAKE, 16'hFFFF,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_INFO},
        '{9'd60,  16'd65535, 4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_B, HOST_A, 16'd65535, 16'd65535, thpc_pkg::REC_HANDSHAKE, 16'h0000,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_INFO},
        '{9'd60,  16'd65535, 4'd5,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd1, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0303,
          thpc_pkg::HS_CLIENT_HELLO, 1'b1, 1'b0, thpc_pkg::EV_NONE},
        '{9'd44,  16'd443,   4'd1,  thpc_pkg::ETHERTYPE_IPV4, thpc_pkg::PROTO_TCP,
          HOST_A, HOST_B, 16'd51018, 16'd443, thpc_pkg::REC_HANDSHAKE, 16'h0303,
          thpc_pkg::HS_CLIENT_HELLO, 1'b0, 1'b0, thpc_pkg::EV_NONE}
    };

    tls_hello_packet_classifier_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_cfg_data      (i_cfg_data),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    initial begin
        #8000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] head_at(input int unsigned idx);
        return (idx < HEADER_BYTES) ? frame_head[idx] : 8'h00;
    endfunction

    function automatic t_verdict classify_hello(input int unsigned frame_bytes);
        t_verdict    v;
        int unsigned tcp_at;
        int unsigned pay_at;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [15:0] rv;
        v = '0;
        if (frame_bytes < 14 || {head_at(12), head_at(13)} != thpc_pkg::ETHERTYPE_IPV4) return v;
        if (frame_bytes < 34 || head_at(23) != thpc_pkg::PROTO_TCP) return v;
        tcp_at = 14 + 4 * (head_at(14) & 8'h0F);
        if (frame_bytes < tcp_at + 20) return v;
        sp = {head_at(tcp_at), head_at(tcp_at + 1)};
        dp = {head_at(tcp_at + 2), head_at(tcp_at + 3)};
        if (sp != port_model && dp != port_model) return v;
        pay_at = tcp_at + 20;
        if (frame_bytes < pay_at + 6) return v;
        if (head_at(pay_at) != thpc_pkg::REC_HANDSHAKE ||
            head_at(pay_at + 5) != thpc_pkg::HS_CLIENT_HELLO) return v;
        rv = {head_at(pay_at + 1), head_at(pay_at + 2)};
        v.drop  = (rv == thpc_pkg::VER_TLS10 || rv == thpc_pkg::VER_TLS11);
        v.ev    = v.drop ? thpc_pkg::EV_LEGACY : thpc_pkg::EV_INFO;
        v.saddr = {head_at(26), head_at(27), head_at(28), head_at(29)};
        v.daddr = {head_at(30), head_at(31), head_at(32), head_at(33)};
        v.sport = sp;
        v.dport = dp;
        v.ver   = rv;
        v.kind  = head_at(pay_at);
        return v;
    endfunction

    function automatic void put16(input int unsigned at, input logic [15:0] value);
        frame_buf[at]     = value[15:8];
        frame_buf[at + 1] = value[7:0];
    endfunction

    // lay header fields over random filler; later ones win, IHL and proto set last
    task automatic compose(input t_frame_row r);
        int unsigned tcp_at;
        tcp_at    = 14 + 4 * r.ihl;
        frame_len = r.len;
        for (int i = 0; i < 512; i++) frame_buf[i] = 8'($urandom);
        put16(12, r.etype);
        frame_buf[14] = {4'h4, r.ihl};
        frame_buf[23] = r.proto;
        put16(26, r.saddr[31:16]);
        put16(28, r.saddr[15:0]);
        put16(30, r.daddr[31:16]);
        put16(32, r.daddr[15:0]);
        put16(tcp_at, r.sport);
        put16(tcp_at + 2, r.dport);
        frame_buf[tcp_at + 20] = r.rkind;
        put16(tcp_at + 21, r.ver);
        frame_buf[tcp_at + 25] = r.hs;
        frame_buf[14][3:0] = r.ihl;
        frame_buf[23] = r.proto;
    endtask

    task automatic pick_random_row(output t_frame_row r);
        int unsigned roll;
        int unsigned pay_end;
        roll    = $urandom_range(0, 99);
        r       = '0;
        r.port  = port_model;
        r.ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
        r.etype = thpc_pkg::ETHERTYPE_IPV4;
        r.proto = thpc_pkg::PROTO_TCP;
        r.saddr = $urandom;
        r.daddr = $urandom;
        r.sport = 16'($urandom);
        r.dport = 16'($urandom);
        if ($urandom_range(0, 1) == 1) begin
            r.dport = port_model;
        end else begin
            r.sport = port_model;
        end
        r.rkind = thpc_pkg::REC_HANDSHAKE;
        r.hs    = thpc_pkg::HS_CLIENT_HELLO;
        case ($urandom_range(0, 5))
            0: r.ver = thpc_pkg::VER_TLS10;
            1: r.ver = thpc_pkg::VER_TLS11;
            2: r.ver = 16'h0303;
            3: r.ver = 16'h0304;
            4: r.ver = 16'h0300;
            default: r.ver = 16'($urandom);
        endcase
        pay_end = 40 + 4 * r.ihl;
        if ($urandom_range(0, 19) == 0) begin
            r.len = 9'($urandom_range(pay_end, 260));
        end else begin
            r.len = 9'(pay_end + $urandom_range(0, 24));
        end
        if (roll >= 90) begin
            r.len   = 9'($urandom_range(1, 160));
            r.rkind = 8'($urandom);
            r.hs    = 8'($urandom);
            if ($urandom_range(0, 1) == 1) r.etype = 16'($urandom);
            if ($urandom_range(0, 1) == 1) r.proto = 8'($urandom);
        end else if (roll >= 65) begin
            case ($urandom_range(0, 5))
                0: r.etype = thpc_pkg::ETHERTYPE_IPV4 ^ 16'($urandom_range(1, 65535));
                1: r.proto = thpc_pkg::PROTO_TCP ^ 8'($urandom_range(1, 255));
                2: begin
                    r.sport = port_model ^ 16'($urandom_range(1, 65535));
                    r.dport = port_model ^ 16'($urandom_range(1, 65535));
                end
                3: r.rkind = thpc_pkg::REC_HANDSHAKE ^ 8'($urandom_range(1, 255));
                4: r.hs = thpc_pkg::HS_CLIENT_HELLO ^ 8'($urandom_range(1, 255));
                default: r.len = 9'($urandom_range(1, pay_end - 1));
            endcase
        end
    endtask

    task automatic push_byte(input logic [7:0] value, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_frame(input bit pinned, input t_verdict typed);
        pinned_flags.push_back(pinned);
        if (pinned) pinned_verdicts.push_back(typed);
        for (int i = 0; i < frame_len; i++) push_byte(frame_buf[i], i == frame_len - 1);
        frames_sent++;
    endtask

    // hold input until every verdict is back, then let the block settle
    task automatic wait_quiet();
        i_s_axis_tvalid <= 1'b0;
        while (verdicts_seen != frames_sent) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_port(input logic [15:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        port_model = value;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            if (head_count < HEADER_BYTES) frame_head[head_count] = i_s_axis_tdata;
            if (i_s_axis_tlast) begin
                if (pinned_flags.pop_front()) begin
                    pending_verdicts.push_back(pinned_verdicts.pop_front());
                end else begin
                    pending_verdicts.push_back(classify_hello(head_count + 1));
                end
                head_count = 0;
            end else if (head_count < HEADER_BYTES) begin
                head_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_word.drop  = o_m_axis_tdata[0];
            got_word.saddr = o_m_axis_tdata[32:1];
            got_word.daddr = o_m_axis_tdata[64:33];
            got_word.sport = o_m_axis_tdata[80:65];
            got_word.dport = o_m_axis_tdata[96:81];
            got_word.ver   = o_m_axis_tdata[112:97];
            got_word.kind  = o_m_axis_tdata[120:113];
            if (pending_verdicts.size() == 0) begin
                $error("result word with no verdict pending");
                fail_count++;
            end else begin
                want_word = pending_verdicts.pop_front();
                check_field("drop_frame", 32'(want_word.drop), 32'(got_word.drop));
                check_field("event_kind", 32'(want_word.ev), 32'(o_m_axis_tuser));
                check_field("source_address", want_word.saddr, got_word.saddr);
                check_field("dest_address", want_word.daddr, got_word.daddr);
                check_field("source_port", 32'(want_word.sport), 32'(got_word.sport));
                check_field("dest_port", 32'(want_word.dport), 32'(got_word.dport));
                check_field("record_version", 32'(want_word.ver), 32'(got_word.ver));
                check_field("record_kind", 32'(want_word.kind), 32'(got_word.kind));
            end
            verdicts_seen++;
        end
    end

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick[7:0] == 8'd0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN: i_m_axis_tready <= 1'b1;
            RX_COIN: i_m_axis_tready <= 1'($urandom_range(0, 1));
            RX_COMB: i_m_axis_tready <= (rx_tick % 5) == 0;
            default: i_m_axis_tready <= rx_tick[5:0] > 6'd40;
        endcase
    end

    initial begin
        t_frame_row  row;
        t_verdict    typed;
        int unsigned rnd_frames;
        logic [15:0] next_port;
        i_rst_n         <= 1'b0;
        i_s_axis_tdata  <= 8'h00;
        i_s_axis_tlast  <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_cfg_data      <= 16'h0000;
        i_cfg_valid     <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            row = directed_rows[n];
            if (row.port != port_model) begin
                wait_quiet();
                write_port(row.port);
            end
            compose(row);
            typed = '0;
            if (row.ev != thpc_pkg::EV_NONE) begin
                typed.drop  = row.drop;
                typed.ev    = row.ev;
                typed.saddr = row.saddr;
                typed.daddr = row.daddr;
                typed.sport = row.sport;
                typed.dport = row.dport;
                typed.ver   = row.ver;
                typed.kind  = row.rkind;
            end
            send_frame(row.pinned, typed);
        end

        rnd_frames = 0;
        while (bytes_sent < ITEM_TARGET || rnd_frames < RANDOM_FRAMES) begin
            if (rnd_frames % PHASE_FRAMES == 0) begin
                wait_quiet();
                case ($urandom_range(0, 5))
                    0: next_port = 16'h0000;
                    1: next_port = 16'hFFFF;
                    2: next_port = thpc_pkg::GUARDED_PORT_RST;
                    default: next_port = 16'($urandom);
                endcase
                write_port(next_port);
                gaps_on = ($urandom_range(0, 3) != 0);
            end else if ($urandom_range(0, 24) == 0) begin
                wait_quiet();
            end
            pick_random_row(row);
            compose(row);
            send_frame(1'b0, '0);
            rnd_frames++;
        end

        wait_quiet();
        if (pending_verdicts.size() != 0) begin
            $error("%0d verdicts never arrived", pending_verdicts.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
